### rtl/pepid_pkg.sv
// Shared constants, types and tables for the polar-error PID controller.
package pepid_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int NUM_REGS         = 8;
    localparam int IDX_W            = 3;

    localparam logic [15:0] KP_DIST_RST   = 16'd256;
    localparam logic [15:0] KP_ANG_RST    = 16'd256;
    localparam logic [15:0] STEP_TIME_RST = 16'd6554;
    localparam logic [15:0] STEP_RATE_RST = 16'd2560;

    localparam logic signed [27:0] ANG_HALF_PI = 28'sd26353589;
    localparam logic signed [27:0] HEAD_MAX    = 28'sd25736;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_KP_DIST   = 3'd0;
    localparam logic [IDX_W-1:0] REG_KI_DIST   = 3'd1;
    localparam logic [IDX_W-1:0] REG_KD_DIST   = 3'd2;
    localparam logic [IDX_W-1:0] REG_KP_ANG    = 3'd3;
    localparam logic [IDX_W-1:0] REG_KI_ANG    = 3'd4;
    localparam logic [IDX_W-1:0] REG_KD_ANG    = 3'd5;
    localparam logic [IDX_W-1:0] REG_STEP_TIME = 3'd6;
    localparam logic [IDX_W-1:0] REG_STEP_RATE = 3'd7;

    typedef struct packed {
        logic [15:0] kp_dist;
        logic [15:0] ki_dist;
        logic [15:0] kd_dist;
        logic [15:0] kp_ang;
        logic [15:0] ki_ang;
        logic [15:0] kd_ang;
        logic [15:0] step_time;
        logic [15:0] step_rate;
    } gains_t;

    // atan(2^-i), 24 fraction bits
    function automatic logic signed [27:0] atan_lut(input logic [4:0] i);
        logic signed [27:0] r;
        begin
            case (i)
                5'd0:    r = 28'sd13176795;
                5'd1:    r = 28'sd7778716;
                5'd2:    r = 28'sd4110060;
                5'd3:    r = 28'sd2086331;
                5'd4:    r = 28'sd1047214;
                5'd5:    r = 28'sd524117;
                5'd6:    r = 28'sd262123;
                5'd7:    r = 28'sd131069;
                5'd8:    r = 28'sd65536;
                5'd9:    r = 28'sd32768;
                5'd10:   r = 28'sd16384;
                5'd11:   r = 28'sd8192;
                5'd12:   r = 28'sd4096;
                5'd13:   r = 28'sd2048;
                5'd14:   r = 28'sd1024;
                5'd15:   r = 28'sd512;
                5'd16:   r = 28'sd256;
                5'd17:   r = 28'sd128;
                5'd18:   r = 28'sd64;
                5'd19:   r = 28'sd32;
                5'd20:   r = 28'sd16;
                5'd21:   r = 28'sd8;
                5'd22:   r = 28'sd4;
                5'd23:   r = 28'sd2;
                default: r = 28'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

### rtl/pepid_if.sv
// Valid/ready channel interfaces for offsets, results and register writes.
interface pepid_in_if (input logic clk);
    logic               valid;
    logic               ready;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    modport source (output valid, offset_x, offset_y, input ready);
    modport sink   (input valid, offset_x, offset_y, output ready);
endinterface

interface pepid_out_if (input logic clk);
    logic               valid;
    logic               ready;
    logic signed [31:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic        [15:0] dist_error;
    logic signed [15:0] heading_error;
    modport source (output valid, linear_cmd, angular_cmd, dist_error, heading_error,
                    input ready);
    modport sink   (input valid, linear_cmd, angular_cmd, dist_error, heading_error,
                    output ready);
endinterface

interface pepid_cfg_if (input logic clk);
    logic                         valid;
    logic                         ready;
    logic [pepid_pkg::IDX_W-1:0]  index;
    logic [15:0]                  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/polar_error_pid_controller.sv
// Top level: CORDIC heading, bitwise square root and two PID channels on one multiplier.
// Accepts one offset at a time: the input is ready only while idle, after the last result is handed on.
// A stalled result holds the next one in the done state until the output register is free.
// CORDIC steps and root bits run side by side, then ten products share the one multiplier.
// Reset (async, rst_n low) restores the default gains and clears history and sums.
module polar_error_pid_controller #(
    parameter int CORDIC_STEPS = pepid_pkg::CORDIC_STEPS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pepid_in_if.sink   in_ch,
    pepid_out_if.source out_ch,
    pepid_cfg_if.sink  cfg
);
    localparam int NSTEP = (CORDIC_STEPS < pepid_pkg::TABLE_LEN) ?
                           CORDIC_STEPS : pepid_pkg::TABLE_LEN;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_ITER, S_ROUND, S_CLAMP, S_SUMS, S_MUL, S_DONE
    } state_t;

    pepid_pkg::gains_t gains;
    pepid_regs u_regs (.clk(clk), .rst_n(rst_n), .cfg(cfg), .gains(gains));

    state_t state_reg;
    logic [4:0] it_reg;
    logic [3:0] op_reg;

    logic signed [15:0] ox_reg, oy_reg;
    logic signed [38:0] cx_reg, cy_reg;
    logic signed [27:0] z_reg;
    logic [31:0] rad_reg;
    logic [16:0] root_reg;
    logic [33:0] rem_reg;
    logic [15:0] ed_reg;
    logic signed [15:0] ea_reg;
    logic [15:0] last_dist_reg;
    logic signed [15:0] last_head_reg;
    logic [31:0] sum_dist_reg;
    logic signed [31:0] sum_head_reg;
    logic signed [55:0] lin_reg, ang_reg;

    logic signed [31:0] lin_o_reg, ang_o_reg;
    logic [15:0] ed_o_reg;
    logic signed [15:0] ea_o_reg;
    logic out_valid_reg;
    logic res_load;

    logic signed [33:0] ma;
    logic signed [17:0] mb;
    logic signed [51:0] mp;
    pepid_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

    // Multiplier schedule: op n issues, its product returns at op n+1
    // 0 kp_d*ed, 1 sumd*dt, 2 kd_d*de, 3 kp_a*ea, 4 suma*dt,
    // 5 (ki_d * t), 6 kd_a*dh, 7 (ki_a * t), 8 rate*t_d, 9 rate*t_a
    logic signed [16:0] de, dh;
    assign de = 17'($signed({1'b0, ed_reg})) - 17'($signed({1'b0, last_dist_reg}));
    assign dh = 17'(ea_reg) - 17'(last_head_reg);

    logic signed [51:0] hold_d_reg, hold_a_reg, it_d_reg, it_a_reg;

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (op_reg)
            4'd0: begin ma = 34'($signed({1'b0, gains.kp_dist})); mb = 18'($signed({1'b0, ed_reg})); end
            4'd1: begin ma = 34'($signed({1'b0, sum_dist_reg})); mb = 18'($signed({1'b0, gains.step_time})); end
            4'd2: begin ma = 34'($signed({1'b0, gains.kd_dist})); mb = 18'(de); end
            4'd3: begin ma = 34'($signed({1'b0, gains.kp_ang})); mb = 18'(ea_reg); end
            4'd4: begin ma = 34'(sum_head_reg); mb = 18'($signed({1'b0, gains.step_time})); end
            4'd5: begin ma = 34'(it_d_reg); mb = 18'($signed({1'b0, gains.ki_dist})); end
            4'd6: begin ma = 34'($signed({1'b0, gains.kd_ang})); mb = 18'(dh); end
            4'd7: begin ma = 34'(it_a_reg); mb = 18'($signed({1'b0, gains.ki_ang})); end
            4'd8: begin ma = 34'(hold_d_reg); mb = 18'($signed({1'b0, gains.step_rate})); end
            4'd9: begin ma = 34'(hold_a_reg); mb = 18'($signed({1'b0, gains.step_rate})); end
            default: ;
        endcase
    end

    // CORDIC step
    logic signed [38:0] sx, sy;
    logic [4:0] sh;
    assign sh = it_reg;
    assign sx = cy_reg >>> sh;
    assign sy = cx_reg >>> sh;

    // root step, 2 bits of radicand per cycle
    logic [33:0] trial;
    logic [33:0] rem_sh;
    assign rem_sh = {rem_reg[31:0], rad_reg[31:30]};
    assign trial  = {15'd0, root_reg, 2'b01};

    logic signed [27:0] zr;
    assign zr = (z_reg + 28'sd1024) >>> 11;

    logic [32:0] sd_sum;
    logic signed [32:0] sh_sum;
    assign sd_sum = {1'b0, sum_dist_reg} + {17'd0, ed_reg};
    assign sh_sum = 33'(sum_head_reg) + 33'(ea_reg);

    function automatic logic signed [31:0] sat(input logic signed [55:0] v);
        if (v > 56'sd2147483647) return 32'sh7fffffff;
        if (v < -56'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // hand the finished word to the output register once the last one is gone
    assign res_load = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready          = (state_reg == S_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.linear_cmd    = lin_o_reg;
    assign out_ch.angular_cmd   = ang_o_reg;
    assign out_ch.dist_error    = ed_o_reg;
    assign out_ch.heading_error = ea_o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            it_reg        <= '0;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
            last_dist_reg <= '0;
            last_head_reg <= '0;
            sum_dist_reg  <= '0;
            sum_head_reg  <= '0;
            ed_reg        <= '0;
            ea_reg        <= '0;
            ed_o_reg      <= '0;
            ea_o_reg      <= '0;
        end
        else
        begin
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        ox_reg    <= in_ch.offset_x;
                        oy_reg    <= in_ch.offset_y;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    rad_reg  <= 32'(ox_reg) * 32'(ox_reg) + 32'(oy_reg) * 32'(oy_reg);
                    root_reg <= '0;
                    rem_reg  <= '0;
                    it_reg   <= '0;
                    if (ox_reg < 0)
                    begin
                        if (oy_reg >= 0)
                        begin
                            cx_reg <= 39'(oy_reg) <<< 20;
                            cy_reg <= -(39'(ox_reg) <<< 20);
                            z_reg  <= pepid_pkg::ANG_HALF_PI;
                        end
                        else
                        begin
                            cx_reg <= -(39'(oy_reg) <<< 20);
                            cy_reg <= 39'(ox_reg) <<< 20;
                            z_reg  <= -pepid_pkg::ANG_HALF_PI;
                        end
                    end
                    else
                    begin
                        cx_reg <= 39'(ox_reg) <<< 20;
                        cy_reg <= 39'(oy_reg) <<< 20;
                        z_reg  <= '0;
                    end
                    state_reg <= S_ITER;
                end
                S_ITER:
                begin
                    if (32'(it_reg) < 32'(NSTEP))
                    begin
                        if (cy_reg >= 0)
                        begin
                            cx_reg <= cx_reg + sx;
                            cy_reg <= cy_reg - sy;
                            z_reg  <= z_reg + pepid_pkg::atan_lut(it_reg);
                        end
                        else
                        begin
                            cx_reg <= cx_reg - sx;
                            cy_reg <= cy_reg + sy;
                            z_reg  <= z_reg - pepid_pkg::atan_lut(it_reg);
                        end
                    end
                    if (it_reg < 5'd16)
                    begin
                        rad_reg <= {rad_reg[29:0], 2'b00};
                        if (rem_sh >= trial)
                        begin
                            rem_reg  <= rem_sh - trial;
                            root_reg <= {root_reg[15:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg  <= rem_sh;
                            root_reg <= {root_reg[15:0], 1'b0};
                        end
                    end
                    it_reg <= it_reg + 5'd1;
                    if (32'(it_reg) + 1 >= ((NSTEP > 16) ? NSTEP : 16))
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    // round to nearest: bump when remainder exceeds root
                    ed_reg <= 16'(root_reg + ((rem_reg > {17'd0, root_reg}) ? 17'd1 : 17'd0));
                    if (ox_reg == 0 && oy_reg == 0)
                    begin
                        z_reg <= '0;
                    end
                    else
                    begin
                        z_reg <= zr;
                    end
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    if (z_reg > pepid_pkg::HEAD_MAX)
                        ea_reg <= 16'(pepid_pkg::HEAD_MAX);
                    else if (z_reg < -pepid_pkg::HEAD_MAX)
                        ea_reg <= 16'(-pepid_pkg::HEAD_MAX);
                    else
                        ea_reg <= 16'(z_reg);
                    state_reg <= S_SUMS;
                end
                S_SUMS:
                begin
                    sum_dist_reg <= sd_sum[32] ? 32'hffffffff : sd_sum[31:0];
                    if (sh_sum > 33'sd2147483647)
                        sum_head_reg <= 32'sh7fffffff;
                    else if (sh_sum < -33'sd2147483648)
                        sum_head_reg <= 32'sh80000000;
                    else
                        sum_head_reg <= sh_sum[31:0];
                    op_reg    <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // collect the product of the previous op
                    case (op_reg)
                        4'd1: lin_reg    <= 56'(mp);
                        4'd2: it_d_reg   <= mp >>> 16;
                        4'd3: hold_d_reg <= mp;
                        4'd4: ang_reg    <= 56'(mp >>> 5);
                        4'd5: it_a_reg   <= mp >>> 16;
                        4'd6: lin_reg    <= lin_reg + 56'(mp);
                        4'd7: hold_a_reg <= mp;
                        4'd8: ang_reg    <= ang_reg + 56'(mp >>> 5);
                        4'd9: lin_reg    <= lin_reg + 56'(mp >>> 8);
                        4'd10: ang_reg   <= ang_reg + 56'(mp >>> 13);
                        default: ;
                    endcase
                    if (op_reg == 4'd10)
                        state_reg <= S_DONE;
                    op_reg <= op_reg + 4'd1;
                end
                S_DONE:
                begin
                    // hold here while the previous word still waits
                    if (res_load)
                    begin
                        lin_o_reg     <= sat(lin_reg);
                        ang_o_reg     <= sat(ang_reg);
                        ed_o_reg      <= ed_reg;
                        ea_o_reg      <= ea_reg;
                        last_dist_reg <= ed_reg;
                        last_head_reg <= ea_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/pepid_regs.sv
// Configuration register file for gains, period and rate.
module pepid_regs (
    input  logic                  clk,
    input  logic                  rst_n,
    pepid_cfg_if.sink             cfg,
    output pepid_pkg::gains_t     gains
);
    pepid_pkg::gains_t gains_reg;

    assign cfg.ready = 1'b1;
    assign gains     = gains_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '{kp_dist:   pepid_pkg::KP_DIST_RST,
                           ki_dist:   16'd0,
                           kd_dist:   16'd0,
                           kp_ang:    pepid_pkg::KP_ANG_RST,
                           ki_ang:    16'd0,
                           kd_ang:    16'd0,
                           step_time: pepid_pkg::STEP_TIME_RST,
                           step_rate: pepid_pkg::STEP_RATE_RST};
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pepid_pkg::REG_KP_DIST:   gains_reg.kp_dist   <= cfg.data;
                pepid_pkg::REG_KI_DIST:   gains_reg.ki_dist   <= cfg.data;
                pepid_pkg::REG_KD_DIST:   gains_reg.kd_dist   <= cfg.data;
                pepid_pkg::REG_KP_ANG:    gains_reg.kp_ang    <= cfg.data;
                pepid_pkg::REG_KI_ANG:    gains_reg.ki_ang    <= cfg.data;
                pepid_pkg::REG_KD_ANG:    gains_reg.kd_ang    <= cfg.data;
                pepid_pkg::REG_STEP_TIME: gains_reg.step_time <= cfg.data;
                pepid_pkg::REG_STEP_RATE: gains_reg.step_rate <= cfg.data;
                default: ;
            endcase
        end
    end
endmodule

### rtl/pepid_mul.sv
// Shared registered signed multiplier, 34 x 18 bits.
module pepid_mul (
    input  logic               clk,
    input  logic signed [33:0] a,
    input  logic signed [17:0] b,
    output logic signed [51:0] p
);
    logic signed [51:0] p_reg;
    assign p = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end
endmodule

### sim/tb.sv
// Testbench for the polar-error PID controller: directed table, then random offsets
// under several gain settings and idling patterns, checked against a predictor or a typed expectation.
`timescale 1ns / 1ps

module tb;
    typedef struct {
        logic signed [31:0] linear_cmd;
        logic signed [31:0] angular_cmd;
        logic        [15:0] dist_error;
        logic signed [15:0] heading_error;
    } command_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 typed;
        command_t           cmd;
    } offset_row_t;

    localparam int  STEPS     = pepid_pkg::CORDIC_STEPS_DEF;
    localparam int  SETTLE    = STEPS + 40;
    localparam longint PI_Q24 = 52707179;
    localparam longint HALF_PI_Q24 = 26353589;
    localparam longint HEADING_LIMIT = 25736;
    localparam longint ARCTAN_Q24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    logic clk;
    logic rst_n;

    pepid_in_if  in_ch (clk);
    pepid_out_if out_ch (clk);
    pepid_cfg_if cfg (clk);

    polar_error_pid_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    pepid_pkg::gains_t gains;
    longint   prev_dist;
    longint   prev_heading;
    longint   dist_sum;
    longint   heading_sum;
    command_t pending_cmds[$];
    int       errors;
    int       idle_pct;
    int       stall_pct;

    always #2 clk = ~clk;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_magnitude(longint x, longint y);
        longint n;
        longint lo;
        longint hi;
        longint mid;
        n = x * x + y * y;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (n > lo * lo + lo)
            lo++;
        return lo;
    endfunction

    function automatic longint cordic_heading(longint x, longint y);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        // fold the left half plane into the right one
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = HALF_PI_Q24;
            end
            else
            begin
                t = x; x = -y; y = t; z = -HALF_PI_Q24;
            end
        end
        x = x <<< 20;
        y = y <<< 20;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ARCTAN_Q24[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ARCTAN_Q24[i];
            end
        end
        z = (z + 1024) >>> 11;
        if (z > HEADING_LIMIT)
            z = HEADING_LIMIT;
        if (z < -HEADING_LIMIT)
            z = -HEADING_LIMIT;
        return z;
    endfunction

    // advance the controller state by one offset and return its command
    function automatic command_t next_command(logic signed [15:0] ox, logic signed [15:0] oy);
        command_t c;
        longint ed;
        longint ea;
        longint p;
        longint it;
        longint d;
        ed = round_magnitude(ox, oy);
        ea = cordic_heading(ox, oy);
        dist_sum = dist_sum + ed;
        if (dist_sum > 64'h0000_0000_FFFF_FFFF)
            dist_sum = 64'h0000_0000_FFFF_FFFF;
        heading_sum = clamp32(heading_sum + ea);

        p  = longint'(gains.kp_dist) * ed;
        it = longint'(gains.ki_dist) * ((dist_sum * longint'(gains.step_time)) >>> 16);
        d  = (longint'(gains.kd_dist) * (ed - prev_dist) * longint'(gains.step_rate)) >>> 8;
        c.linear_cmd = clamp32(p + it + d);

        p  = (longint'(gains.kp_ang) * ea) >>> 5;
        it = (longint'(gains.ki_ang) *
              ((heading_sum * longint'(gains.step_time)) >>> 16)) >>> 5;
        d  = (longint'(gains.kd_ang) * (ea - prev_heading) *
              longint'(gains.step_rate)) >>> 13;
        c.angular_cmd = clamp32(p + it + d);

        c.dist_error    = ed[15:0];
        c.heading_error = ea[15:0];
        prev_dist    = ed;
        prev_heading = ea;
        return c;
    endfunction

    task automatic send_offset(logic signed [15:0] ox, logic signed [15:0] oy,
                               bit typed, command_t typed_cmd);
        command_t c;
        if ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_ch.valid    <= 1'b1;
        in_ch.offset_x <= ox;
        in_ch.offset_y <= oy;
        do
            @(posedge clk);
        while (!in_ch.ready);
        c = next_command(ox, oy);
        pending_cmds.push_back(typed ? typed_cmd : c);
    endtask

    // leave valid high; the caller drops it after the last write
    task automatic write_reg(logic [pepid_pkg::IDX_W-1:0] idx, logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        case (idx)
            pepid_pkg::REG_KP_DIST:   gains.kp_dist   = value;
            pepid_pkg::REG_KI_DIST:   gains.ki_dist   = value;
            pepid_pkg::REG_KD_DIST:   gains.kd_dist   = value;
            pepid_pkg::REG_KP_ANG:    gains.kp_ang    = value;
            pepid_pkg::REG_KI_ANG:    gains.ki_ang    = value;
            pepid_pkg::REG_KD_ANG:    gains.kd_ang    = value;
            pepid_pkg::REG_STEP_TIME: gains.step_time = value;
            pepid_pkg::REG_STEP_RATE: gains.step_rate = value;
            default: ;
        endcase
    endtask

    task automatic load_gains(pepid_pkg::gains_t g);
        in_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        write_reg(pepid_pkg::REG_STEP_RATE, g.step_rate);
        write_reg(pepid_pkg::REG_KP_DIST,   g.kp_dist);
        write_reg(pepid_pkg::REG_KI_DIST,   g.ki_dist);
        write_reg(pepid_pkg::REG_KD_DIST,   g.kd_dist);
        write_reg(pepid_pkg::REG_KP_ANG,    g.kp_ang);
        write_reg(pepid_pkg::REG_KI_ANG,    g.ki_ang);
        write_reg(pepid_pkg::REG_KD_ANG,    g.kd_ang);
        write_reg(pepid_pkg::REG_STEP_TIME, g.step_time);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_coord(int kind);
        logic signed [15:0] corners [5] = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(2048) - 1024);
            2: return corners[$urandom_range(4)];
            default: return 16'($urandom_range(200) - 100);
        endcase
    endfunction

    function automatic pepid_pkg::gains_t random_gains(int maxval);
        pepid_pkg::gains_t g;
        g.kp_dist   = 16'($urandom_range(maxval));
        g.ki_dist   = 16'($urandom_range(maxval));
        g.kd_dist   = 16'($urandom_range(maxval));
        g.kp_ang    = 16'($urandom_range(maxval));
        g.ki_ang    = 16'($urandom_range(maxval));
        g.kd_ang    = 16'($urandom_range(maxval));
        g.step_time = 16'($urandom_range(65535, 1));
        g.step_rate = 16'($urandom_range(65535, 1));
        return g;
    endfunction

    // result side: stall at random, check each word against the oldest expectation
    initial
    begin
        command_t want;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_cmds.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result lin=%0d ang=%0d dist=%0d head=%0d",
                             $realtime, out_ch.linear_cmd, out_ch.angular_cmd,
                             out_ch.dist_error, out_ch.heading_error);
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (out_ch.linear_cmd !== want.linear_cmd)
                    begin
                        errors++;
                        $display("%0t: linear_cmd expected %0d actual %0d",
                                 $realtime, want.linear_cmd, out_ch.linear_cmd);
                    end
                    if (out_ch.angular_cmd !== want.angular_cmd)
                    begin
                        errors++;
                        $display("%0t: angular_cmd expected %0d actual %0d",
                                 $realtime, want.angular_cmd, out_ch.angular_cmd);
                    end
                    if (out_ch.dist_error !== want.dist_error)
                    begin
                        errors++;
                        $display("%0t: dist_error expected %0d actual %0d",
                                 $realtime, want.dist_error, out_ch.dist_error);
                    end
                    if (out_ch.heading_error !== want.heading_error)
                    begin
                        errors++;
                        $display("%0t: heading_error expected %0d actual %0d",
                                 $realtime, want.heading_error, out_ch.heading_error);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        offset_row_t rows [$];
        offset_row_t r;
        command_t    zero_cmd;
        pepid_pkg::gains_t g;
        int          mode_idle [4] = '{0, 84, 0, 9};
        int          mode_stall [4] = '{0, 0, 84, 9};

        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.offset_x = '0;
        in_ch.offset_y = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        errors = 0;
        idle_pct = 0;
        stall_pct = 0;
        gains = '{kp_dist: pepid_pkg::KP_DIST_RST, ki_dist: 16'd0, kd_dist: 16'd0,
                  kp_ang: pepid_pkg::KP_ANG_RST, ki_ang: 16'd0, kd_ang: 16'd0,
                  step_time: pepid_pkg::STEP_TIME_RST, step_rate: pepid_pkg::STEP_RATE_RST};
        prev_dist = 0;
        prev_heading = 0;
        dist_sum = 0;
        heading_sum = 0;
        zero_cmd = '{default: '0};

        // zero offset straight after reset gives all-zero outputs
        rows.push_back('{16'sd0, 16'sd0, 1'b1, zero_cmd});
        rows.push_back('{16'sh7FFF, 16'sd0, 1'b0, zero_cmd});
        rows.push_back('{16'sh8000, 16'sd0, 1'b0, zero_cmd});
        rows.push_back('{16'sd0, 16'sh7FFF, 1'b0, zero_cmd});
        rows.push_back('{16'sd0, 16'sh8000, 1'b0, zero_cmd});
        rows.push_back('{16'sh8000, 16'sh8000, 1'b0, zero_cmd});
        rows.push_back('{16'sh7FFF, 16'sh7FFF, 1'b0, zero_cmd});
        rows.push_back('{16'sh8000, 16'sh7FFF, 1'b0, zero_cmd});
        rows.push_back('{16'sh7FFF, 16'sh8000, 1'b0, zero_cmd});
        rows.push_back('{-16'sd1, 16'sd0, 1'b0, zero_cmd});
        rows.push_back('{-16'sd256, 16'sd0, 1'b0, zero_cmd});
        rows.push_back('{16'sd1, 16'sd0, 1'b0, zero_cmd});
        rows.push_back('{16'sd0, 16'sd1, 1'b0, zero_cmd});
        rows.push_back('{16'sd0, -16'sd1, 1'b0, zero_cmd});
        rows.push_back('{-16'sd1, -16'sd1, 1'b0, zero_cmd});
        rows.push_back('{-16'sd1, 16'sd1, 1'b0, zero_cmd});
        rows.push_back('{16'sd100, -16'sd5, 1'b0, zero_cmd});
        rows.push_back('{16'sd0, 16'sd0, 1'b0, zero_cmd});
        rows.push_back('{16'sh5555, 16'shAAAA, 1'b0, zero_cmd});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            r = rows[i];
            send_offset(r.x, r.y, r.typed, r.cmd);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                1: g = '{default: 16'hFFFF};
                2: g = '{default: 16'h0000};
                3: g = '{kp_dist: 16'hFFFF, kp_ang: 16'hFFFF, step_time: 16'd1,
                         step_rate: 16'd1, default: 16'd1};
                5: g = random_gains(1023);
                7: g = '{kp_dist: pepid_pkg::KP_DIST_RST, ki_dist: 16'd0, kd_dist: 16'd0,
                         kp_ang: pepid_pkg::KP_ANG_RST, ki_ang: 16'd0, kd_ang: 16'd0,
                         step_time: pepid_pkg::STEP_TIME_RST,
                         step_rate: pepid_pkg::STEP_RATE_RST};
                default: g = random_gains(65535);
            endcase
            load_gains(g);
            idle_pct  = mode_idle[ph % 4];
            stall_pct = mode_stall[ph % 4];
            for (int n = 0; n < 200; n++)
                send_offset(pick_coord($urandom_range(3)), pick_coord($urandom_range(3)),
                            1'b0, zero_cmd);
        end

        in_ch.valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
